[src/kbdrpt_pkg.sv]
// Shared constants, types and keymap ROM for the keyboard matrix report builder.
package kbdrpt_pkg;

    localparam int DEF_SCAN_ROWS     = 7;
    localparam int DEF_SENSE_COLUMNS = 6;
    localparam int DEF_KEYMAP_HALVES = 2;
    localparam int DEF_REPORT_KEYS   = 6;

    localparam int ROM_HALVES = 2;
    localparam int ROM_ROWS   = 7;
    localparam int ROM_COLS   = 6;
    localparam int SLOTS      = 6;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 3;
    localparam int FILL_W     = 3;
    localparam int SENSE_W    = 6;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 16;

    localparam logic [ROW_W-1:0] ROW_RELEASED = 3'd7;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic  pressed;
        byte_t mods;
        byte_t key;
    } lane_t;

    localparam logic [CODE_W-1:0] KEYMAP [ROM_HALVES][ROM_ROWS][ROM_COLS] = '{
        '{
            '{16'h0000, 16'h0017, 16'h0022, 16'h0000, 16'h0029, 16'h002b},
            '{16'h0019, 16'h0009, 16'h0015, 16'h0021, 16'h000a, 16'h0005},
            '{16'h004d, 16'h0007, 16'h0008, 16'h0020, 16'h0006, 16'h0000},
            '{16'h004a, 16'h0004, 16'h0014, 16'h001e, 16'h001d, 16'h0000},
            '{16'h0039, 16'h002c, 16'h0000, 16'h0000, 16'h0200, 16'h008b},
            '{16'h0035, 16'h002f, 16'h0032, 16'h0030, 16'h0400, 16'h0100},
            '{16'h004e, 16'h0016, 16'h001a, 16'h001f, 16'h001b, 16'h004b}
        },
        '{
            '{16'h0028, 16'h0000, 16'h001c, 16'h0023, 16'h0049, 16'h0000},
            '{16'h0011, 16'h0010, 16'h000d, 16'h0018, 16'h000b, 16'h0024},
            '{16'h0052, 16'h0051, 16'h000f, 16'h0012, 16'h0037, 16'h0026},
            '{16'h0000, 16'h004f, 16'h0033, 16'h0013, 16'h0038, 16'h0027},
            '{16'h1000, 16'h004c, 16'h0089, 16'h002d, 16'h4000, 16'h002e},
            '{16'h0000, 16'h0050, 16'h000e, 16'h000c, 16'h0036, 16'h0025},
            '{16'h008a, 16'h0088, 16'h2000, 16'h0000, 16'h002a, 16'h0000}
        }
    };

    function automatic logic [CODE_W-1:0] keymap_code(
        input logic             half,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [CODE_W-1:0] code;
        code = '0;
        if (row < ROW_W'(ROM_ROWS) && col < COL_W'(ROM_COLS)) begin
            code = KEYMAP[half][row][col];
        end
        return code;
    endfunction

endpackage

[src/kbdrpt_scan_if.sv]
// Scan tick channel: half-select level and active-low sense lines.
interface kbdrpt_scan_if;
    import kbdrpt_pkg::*;

    logic               valid;
    logic               ready;
    logic               side_level;
    logic [SENSE_W-1:0] sense_bits;

    modport source (output valid, side_level, sense_bits, input ready);
    modport sink   (input valid, side_level, sense_bits, output ready);
endinterface

[src/kbdrpt_report_if.sv]
// Report channel: row drive, ready flag and the latched boot report.
interface kbdrpt_report_if;
    import kbdrpt_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_drive;
    logic             report_ready;
    byte_t            report_modifiers;
    byte_t            report_key0;
    byte_t            report_key1;
    byte_t            report_key2;
    byte_t            report_key3;
    byte_t            report_key4;
    byte_t            report_key5;

    modport source (
        output valid, row_drive, report_ready, report_modifiers,
               report_key0, report_key1, report_key2, report_key3,
               report_key4, report_key5,
        input  ready
    );
    modport sink (
        input  valid, row_drive, report_ready, report_modifiers,
               report_key0, report_key1, report_key2, report_key3,
               report_key4, report_key5,
        output ready
    );
endinterface

[src/kbdrpt_lane.sv]
// One column lane: sense decode and keymap lookup for a fixed column.
module kbdrpt_lane
    import kbdrpt_pkg::*;
#(
    parameter int COL = 0
)(
    input  logic             half,
    input  logic [ROW_W-1:0] row,
    input  logic             sense_n,
    output lane_t            result
);

    logic [CODE_W-1:0] code;

    assign code           = keymap_code(half, row, COL_W'(COL));
    assign result.pressed = ~sense_n;
    assign result.mods    = code[CODE_W-1:BYTE_W];
    assign result.key     = code[BYTE_W-1:0];

endmodule

[src/kbdrpt_merge.sv]
// Merge stage: folds lane hits into pending modifiers and key slots in column order.
module kbdrpt_merge
    import kbdrpt_pkg::*;
#(
    parameter int LANES       = DEF_SENSE_COLUMNS,
    parameter int REPORT_KEYS = DEF_REPORT_KEYS
)(
    input  lane_t             lanes      [LANES],
    input  logic [FILL_W-1:0] fill_cnt,
    input  byte_t             mods,
    input  byte_t             keys       [SLOTS],
    output logic [FILL_W-1:0] fill_next,
    output byte_t             mods_next,
    output byte_t             keys_next  [SLOTS]
);

    localparam logic [FILL_W-1:0] CAP = FILL_W'(REPORT_KEYS);

    logic [FILL_W-1:0] cnt;
    byte_t             m;
    byte_t             k [SLOTS];

    always_comb
    begin
        cnt = fill_cnt;
        m   = mods;
        k   = keys;
        for (int c = 0; c < LANES; c++)
        begin
            if (lanes[c].pressed)
            begin
                m = m | lanes[c].mods;
                if (lanes[c].key != '0 && cnt < CAP)
                begin
                    k[cnt] = lanes[c].key;
                    cnt    = cnt + FILL_W'(1);
                end
            end
        end
        fill_next = cnt;
        mods_next = m;
        keys_next = k;
    end

endmodule

[src/keyboard_matrix_hid_report_builder.sv]
// Top level: keyboard matrix scan sequencer building a HID boot keyboard report.
//
// Channels: scan (sink) takes one scan tick per item: side_level and the six
// active-low sense lines. report (source) gives one item per tick: the row to
// drive on this tick, a flag for a freshly latched report, and the latched
// modifier byte and six key slots.
// The sequencer cycles through 2*SCAN_ROWS+1 phases: even phases drive a row,
// odd phases sample it through one keymap lane per column and a merge stage,
// and the last phase latches the report and clears the pending state.
// Latency: the result of a tick is registered and valid on the cycle after it
// is accepted. Throughput: one tick per cycle while the output is taken; all
// work for a tick is done in the accept cycle, bounded by the six-lane merge chain.
// Stall: the output register holds its item until taken; scan.ready stays high
// while the register is empty or being drained in the same cycle.
// Reset: phase, fill count, modifiers and latched report clear to zero and the
// output register empties; pending key slots are written before use.
module keyboard_matrix_hid_report_builder
    import kbdrpt_pkg::*;
#(
    parameter int SCAN_ROWS     = DEF_SCAN_ROWS,
    parameter int SENSE_COLUMNS = DEF_SENSE_COLUMNS,
    parameter int KEYMAP_HALVES = DEF_KEYMAP_HALVES,
    parameter int REPORT_KEYS   = DEF_REPORT_KEYS
)(
    input  logic                    clk,
    input  logic                    rst_n,
    kbdrpt_scan_if.sink             scan,
    kbdrpt_report_if.source         report
);

    localparam int LAST_PHASE = 2 * SCAN_ROWS;
    localparam int PHASE_W    = $clog2(LAST_PHASE + 1);
    localparam int LANES      = (SENSE_COLUMNS < ROM_COLS) ? SENSE_COLUMNS : ROM_COLS;
    localparam logic [PHASE_W-1:0] LAST = PHASE_W'(LAST_PHASE);

    logic [PHASE_W-1:0] phase_reg,        phase_next;
    logic [FILL_W-1:0]  fill_count_reg,   fill_count_next;
    byte_t              pend_mods_reg,    pend_mods_next;
    byte_t              pend_keys_reg     [SLOTS];
    byte_t              pend_keys_next    [SLOTS];
    byte_t              latch_mods_reg,   latch_mods_next;
    byte_t              latch_keys_reg    [SLOTS];
    byte_t              latch_keys_next   [SLOTS];
    logic [ROW_W-1:0]   row_drive_reg,    row_drive_next;
    logic               rpt_flag_reg,     rpt_flag_next;
    logic               out_valid_reg,    out_valid_next;

    logic               accept;
    logic               is_last;
    logic               is_odd;
    logic [ROW_W-1:0]   row;
    logic               half;
    lane_t              lanes             [LANES];
    logic [FILL_W-1:0]  merge_fill;
    byte_t              merge_mods;
    byte_t              merge_keys        [SLOTS];

    assign scan.ready = ~out_valid_reg | report.ready;
    assign accept     = scan.valid & scan.ready;
    assign is_last    = (phase_reg >= LAST);
    assign is_odd     = phase_reg[0];
    assign row        = ROW_W'(phase_reg >> 1);
    assign half       = (KEYMAP_HALVES == 1) ? 1'b0 : ~scan.side_level;

    for (genvar c = 0; c < LANES; c++)
    begin : g_lane
        kbdrpt_lane #(
            .COL (c)
        ) u_lane (
            .half    (half),
            .row     (row),
            .sense_n (scan.sense_bits[c]),
            .result  (lanes[c])
        );
    end

    kbdrpt_merge #(
        .LANES       (LANES),
        .REPORT_KEYS (REPORT_KEYS)
    ) u_merge (
        .lanes     (lanes),
        .fill_cnt  (fill_count_reg),
        .mods      (pend_mods_reg),
        .keys      (pend_keys_reg),
        .fill_next (merge_fill),
        .mods_next (merge_mods),
        .keys_next (merge_keys)
    );

    always_comb
    begin
        phase_next      = phase_reg;
        fill_count_next = fill_count_reg;
        pend_mods_next  = pend_mods_reg;
        pend_keys_next  = pend_keys_reg;
        latch_mods_next = latch_mods_reg;
        latch_keys_next = latch_keys_reg;
        row_drive_next  = row_drive_reg;
        rpt_flag_next   = rpt_flag_reg;
        out_valid_next  = out_valid_reg & ~report.ready;
        if (accept)
        begin
            out_valid_next = 1'b1;
            row_drive_next = ROW_RELEASED;
            rpt_flag_next  = 1'b0;
            if (is_last)
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    latch_keys_next[s] = (FILL_W'(s) < fill_count_reg) ? pend_keys_reg[s] : '0;
                end
                latch_mods_next = pend_mods_reg;
                fill_count_next = '0;
                pend_mods_next  = '0;
                rpt_flag_next   = 1'b1;
                phase_next      = '0;
            end
            else
            begin
                phase_next = phase_reg + PHASE_W'(1);
                if (is_odd)
                begin
                    fill_count_next = merge_fill;
                    pend_mods_next  = merge_mods;
                    pend_keys_next  = merge_keys;
                end
                else
                begin
                    row_drive_next = row;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            fill_count_reg <= '0;
            pend_mods_reg  <= '0;
            latch_mods_reg <= '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                latch_keys_reg[s] <= '0;
            end
            rpt_flag_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            fill_count_reg <= fill_count_next;
            pend_mods_reg  <= pend_mods_next;
            latch_mods_reg <= latch_mods_next;
            latch_keys_reg <= latch_keys_next;
            rpt_flag_reg   <= rpt_flag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_keys_reg <= pend_keys_next;
        row_drive_reg <= row_drive_next;
    end

    assign report.valid            = out_valid_reg;
    assign report.row_drive        = row_drive_reg;
    assign report.report_ready     = rpt_flag_reg;
    assign report.report_modifiers = latch_mods_reg;
    assign report.report_key0      = latch_keys_reg[0];
    assign report.report_key1      = latch_keys_reg[1];
    assign report.report_key2      = latch_keys_reg[2];
    assign report.report_key3      = latch_keys_reg[3];
    assign report.report_key4      = latch_keys_reg[4];
    assign report.report_key5      = latch_keys_reg[5];

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_W'(REPORT_KEYS))
        else $error("fill count beyond report capacity");

    a_latch_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_last) |=> (rpt_flag_reg && out_valid_reg && phase_reg == '0))
        else $error("latch tick did not flag report and restart phase");

    a_latch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_last) |=> (fill_count_reg == '0 && pend_mods_reg == '0))
        else $error("pending state not cleared at latch");

    a_flag_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rpt_flag_reg) |-> (row_drive_reg == ROW_RELEASED))
        else $error("row driven on latch tick");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !report.ready) |=> $stable(phase_reg))
        else $error("tick taken while result stalled");

endmodule
